// File: sv/ssa_pkg.sv
// Shared types, codes and constants of the strided scatter-add accumulator.
package ssa_pkg;

	localparam int SSA_STORE_DEPTH = 4096;
	localparam int SSA_VALUE_WIDTH = 32;
	localparam int MAX_RANK        = 4;
	localparam int NUM_AXES        = 4;
	localparam int USED_AXES       = (MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES;

	localparam int DATA_W    = 32;
	localparam int COORD_W   = 12;
	localparam int STRIDE_W  = 12;
	localparam int SEL_W     = 16;
	localparam int EXTENT_W  = 13;
	localparam int AXIS_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;

	// Non-negative index magnitude, coordinates zero-extended to it.
	localparam int C_W    = SEL_W - 1;
	localparam int PROD_W = C_W + STRIDE_W;
	localparam int OFS_W  = PROD_W + ((USED_AXES > 1) ? $clog2(USED_AXES) : 0);

	localparam logic CMD_ACCUM = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_OFS   = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_SELECT_AXIS  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AXIS_EXTENT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STRIDE_AXIS0 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STRIDE_AXIS1 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_STRIDE_AXIS2 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STRIDE_AXIS3 = 3'd5;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] grad_value;
		logic [COORD_W-1:0]       coord0;
		logic [COORD_W-1:0]       coord1;
		logic [COORD_W-1:0]       coord2;
		logic [COORD_W-1:0]       coord3;
		logic signed [SEL_W-1:0]  sel_index;
	} ssa_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic [STATUS_W-1:0]      status;
	} ssa_rsp_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} ssa_cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DONE
	} ssa_state_t;

endpackage

// File: sv/ssa_chan_if.sv
// Valid/ready channel carrying one payload type.
interface ssa_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: sv/strided_scatter_add_accumulator_unit.sv
// Strided scatter-add accumulator: offset formation, store read-modify-write, result register.
//
// Each request passes through four steps: accept, per-axis multiply of coordinate by stride,
// offset sum with bounds check and store read, then write-back and result load. The next
// request is accepted in the cycle after the result is loaded into the output register,
// so a busy consumer only stalls the block once that register is still full. The store is
// a single memory with one write and one registered read port; after reset it is swept to
// zero, and no request is accepted during the sweep (configuration writes are taken
// throughout).
module strided_scatter_add_accumulator_unit
	import ssa_pkg::*;
#(
	parameter int STORE_DEPTH = SSA_STORE_DEPTH,
	parameter int VALUE_WIDTH = SSA_VALUE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	ssa_chan_if.sink   in,
	ssa_chan_if.source out,
	ssa_chan_if.sink   cfg
);

	localparam int AW = $clog2(STORE_DEPTH);

	ssa_state_t state_q, state_d;

	logic [AXIS_W-1:0]   select_axis_q;
	logic [EXTENT_W-1:0] axis_extent_q;
	logic [STRIDE_W-1:0] stride_q [NUM_AXES];

	ssa_req_t            req_q;
	logic [PROD_W-1:0]   prod_q [USED_AXES];
	logic                idx_bad_q;
	logic [AW-1:0]       offset_q;
	logic [STATUS_W-1:0] status_q;
	logic [AW-1:0]       clr_cnt_q;

	logic                   out_valid_q;
	ssa_rsp_t               out_item_q;

	logic [VALUE_WIDTH-1:0] accum_mem [STORE_DEPTH];
	logic signed [VALUE_WIDTH-1:0] rdata_q;

	logic [COORD_W-1:0]     coord_w [NUM_AXES];
	logic [OFS_W-1:0]       offset_w;
	logic [STATUS_W-1:0]    status_w;
	logic                   accept_w;
	logic                   out_load_w;
	logic                   mem_we_w;
	logic [AW-1:0]          mem_waddr_w;
	logic [VALUE_WIDTH-1:0] mem_wdata_w;
	ssa_rsp_t               rsp_w;

	assign cfg.ready  = 1'b1;
	assign accept_w   = in.valid && in.ready;
	assign out.valid  = out_valid_q;
	assign out.payload = out_item_q;

	assign coord_w[0] = req_q.coord0;
	assign coord_w[1] = req_q.coord1;
	assign coord_w[2] = req_q.coord2;
	assign coord_w[3] = req_q.coord3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_axis_q <= '0;
			axis_extent_q <= EXTENT_W'(1);
			stride_q[0]   <= '0;
			stride_q[1]   <= '0;
			stride_q[2]   <= '0;
			stride_q[3]   <= STRIDE_W'(1);
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				REG_SELECT_AXIS:  select_axis_q <= cfg.payload.data[AXIS_W-1:0];
				REG_AXIS_EXTENT:  axis_extent_q <= cfg.payload.data[EXTENT_W-1:0];
				REG_STRIDE_AXIS0: stride_q[0] <= cfg.payload.data[STRIDE_W-1:0];
				REG_STRIDE_AXIS1: stride_q[1] <= cfg.payload.data[STRIDE_W-1:0];
				REG_STRIDE_AXIS2: stride_q[2] <= cfg.payload.data[STRIDE_W-1:0];
				REG_STRIDE_AXIS3: stride_q[3] <= cfg.payload.data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_cnt_q == AW'(STORE_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept_w) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_DONE;
			ST_DONE:  if (out_load_w) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		in.ready    = 1'b0;
		out_load_w  = 1'b0;
		mem_we_w    = 1'b0;
		mem_waddr_w = offset_q;
		mem_wdata_w = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we_w    = 1'b1;
				mem_waddr_w = clr_cnt_q;
			end
			ST_IDLE: in.ready = 1'b1;
			ST_DONE: begin
				out_load_w = !out_valid_q || out.ready;
				mem_we_w   = out_load_w && (status_q == STATUS_OK);
				if (req_q.cmd == CMD_ACCUM) begin
					mem_wdata_w = rdata_q + VALUE_WIDTH'(req_q.grad_value);
				end
			end
			default: ;
		endcase
	end

	// offset sum and bounds check
	always_comb begin
		offset_w = '0;
		for (int a = 0; a < USED_AXES; a++) begin
			offset_w = offset_w + OFS_W'(prod_q[a]);
		end
		if (idx_bad_q) begin
			status_w = STATUS_BAD_INDEX;
		end else if (offset_w >= OFS_W'(STORE_DEPTH)) begin
			status_w = STATUS_BAD_OFS;
		end else begin
			status_w = STATUS_OK;
		end
	end

	always_comb begin
		rsp_w.status    = status_q;
		rsp_w.read_data = '0;
		if (status_q == STATUS_OK && req_q.cmd == CMD_READ) begin
			rsp_w.read_data = DATA_W'(rdata_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (out_load_w) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept_w) begin
			req_q <= in.payload;
		end
		if (state_q == ST_MUL) begin
			idx_bad_q <= req_q.sel_index[SEL_W-1] ||
				({1'b0, req_q.sel_index[C_W-1:0]} >= SEL_W'(axis_extent_q));
			for (int a = 0; a < USED_AXES; a++) begin
				if (select_axis_q == AXIS_W'(a)) begin
					prod_q[a] <= PROD_W'(req_q.sel_index[C_W-1:0]) * PROD_W'(stride_q[a]);
				end else begin
					prod_q[a] <= PROD_W'(coord_w[a]) * PROD_W'(stride_q[a]);
				end
			end
		end
		if (state_q == ST_SUM) begin
			offset_q <= offset_w[AW-1:0];
			status_q <= status_w;
		end
		if (out_load_w) begin
			out_item_q <= rsp_w;
		end
	end

	// accumulator store, one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we_w) begin
			accum_mem[mem_waddr_w] <= mem_wdata_w;
		end
		rdata_q <= accum_mem[offset_w[AW-1:0]];
	end

endmodule
